FILE: src/kbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbt_pkg: shared constants for the k-bucket table
// Table sizes, field widths and command codes used by the table and its bench.
// ----------------------------------------------------------------------------
package kbt_pkg;
  localparam int CAPACITY = 20;
  localparam int ID_BITS  = 64;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_CONTAINS = 3'd2;
  localparam logic [2:0] CMD_LIST     = 3'd3;
  localparam logic [2:0] CMD_CLOSEST  = 3'd4;
endpackage
`default_nettype wire

FILE: src/xor_distance_kbucket_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_distance_kbucket_table: recency-ordered peer table
// Remove and contains search the slots one by one and add then rotates the row; a
// list result gives one entry per transfer; closest scans the slots anew for each
// entry emitted, with the single shared XOR-distance compare unit.
// One command at a time; in_ready is low while a command is at work.
// Reset (rst, synchronous) empties the table and sets the capacity to 20.
// ----------------------------------------------------------------------------
module xor_distance_kbucket_table import kbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [63:0] node_id,
  input  wire logic [15:0] node_port,
  input  wire logic [31:0] node_address,
  input  wire logic [6:0]  want_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic             entry_valid,
  output logic [63:0]      entry_id,
  output logic [15:0]      entry_port,
  output logic [31:0]      entry_address,
  output logic             last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIND = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Table storage, one register per slot so that shifts move the whole row.
  logic [ID_BITS-1:0] ids   [CAPACITY];
  logic [15:0]        ports [CAPACITY];
  logic [31:0]        addrs [CAPACITY];
  logic [CAPACITY-1:0] used;
  logic [CNT_W-1:0]   count;
  logic [6:0]         capacity;

  logic [2:0]         state;
  logic [2:0]         cmd;
  logic [ID_BITS-1:0] key;
  logic [15:0]        kport;
  logic [31:0]        kaddr;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   n_out;
  logic [CNT_W-1:0]   emitted;
  logic               found;
  logic [SLOT_W-1:0]  hit;
  logic               have;
  logic [ID_BITS-1:0] best_d;
  logic [SLOT_W-1:0]  best;

  logic [SLOT_W-1:0]  slot;
  logic [ID_BITS-1:0] xdist;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   want_c;

  assign slot      = idx[SLOT_W-1:0];
  assign xdist     = ids[slot] ^ key;
  assign limit     = (capacity > 7'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(capacity);
  assign want_c    = (want_count > 7'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(want_count);
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  // Sequencer and shared compare unit.
  always_ff @(posedge clk) begin
    logic load_out;
    load_out = 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= 7'd20;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd     <= command;
            key     <= node_id[ID_BITS-1:0];
            kport   <= node_port;
            kaddr   <= node_address;
            idx     <= '0;
            found   <= 1'b0;
            emitted <= '0;
            have    <= 1'b0;
            used    <= '0;
            if (command == CMD_LIST) begin
              n_out <= (want_count == 7'd0 || CNT_W'(want_c) >= count) ? count : want_c;
              state <= S_LIST;
            end else if (command == CMD_CLOSEST) begin
              n_out <= (want_c < count) ? want_c : count;
              state <= S_SCAN;
            end else if (command == CMD_ADD || command == CMD_REMOVE ||
                         command == CMD_CONTAINS) begin
              state <= S_FIND;
            end else begin
              ok <= 1'b0; entry_valid <= 1'b0; last <= 1'b1;
              entry_id <= '0; entry_port <= '0; entry_address <= '0;
              load_out = 1'b1;
            end
          end
        end
        // Linear search for the id, one slot a cycle.
        S_FIND: begin
          if (idx < count && !found) begin
            if (ids[slot] == key) begin
              found <= 1'b1;
              hit   <= slot;
            end
            idx <= idx + 1'b1;
          end else begin
            entry_valid <= 1'b0; last <= 1'b1;
            entry_id <= '0; entry_port <= '0; entry_address <= '0;
            if (cmd == CMD_CONTAINS) begin
              ok <= found; load_out = 1'b1; state <= S_IDLE;
            end else if (cmd == CMD_REMOVE) begin
              ok <= found; load_out = 1'b1; state <= S_IDLE;
              if (found) begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (SLOT_W'(i) >= hit) begin
                    ids[i] <= ids[i+1]; ports[i] <= ports[i+1]; addrs[i] <= addrs[i+1];
                  end
                end
                count <= count - 1'b1;
              end
            end else begin
              state <= S_MOVE;
            end
          end
        end
        // Add: rotate the slots up to the hit (or the end) and write slot 0, or refuse a new id when full.
        S_MOVE: begin
          entry_valid <= 1'b0; last <= 1'b1;
          entry_id <= '0; entry_port <= '0; entry_address <= '0;
          load_out = 1'b1;
          state     <= S_IDLE;
          if (found || count < limit) begin
            for (int i = 1; i < CAPACITY; i++) begin
              if (found ? (SLOT_W'(i) <= hit) : (CNT_W'(i) <= count)) begin
                ids[i] <= ids[i-1]; ports[i] <= ports[i-1]; addrs[i] <= addrs[i-1];
              end
            end
            ids[0] <= key; ports[0] <= kport; addrs[0] <= kaddr;
            if (!found) count <= count + 1'b1;
            ok <= 1'b1;
          end else begin
            ok <= 1'b0;
          end
        end
        // List: one slot a transfer in recency order.
        S_LIST: begin
          if (!out_valid || out_ready) begin
            if (n_out == '0) begin
              ok <= 1'b0; entry_valid <= 1'b0; last <= 1'b1;
              entry_id <= '0; entry_port <= '0; entry_address <= '0;
              load_out = 1'b1; state <= S_IDLE;
            end else begin
              ok <= 1'b1; entry_valid <= 1'b1;
              entry_id <= 64'(ids[slot]); entry_port <= ports[slot];
              entry_address <= addrs[slot];
              last <= (idx + 1'b1 == n_out);
              load_out = 1'b1;
              idx <= idx + 1'b1;
              if (idx + 1'b1 == n_out) state <= S_IDLE;
            end
          end
        end
        // Closest: minimum search over unused slots, one compare a cycle.
        S_SCAN: begin
          if (n_out == '0) begin
            ok <= 1'b0; entry_valid <= 1'b0; last <= 1'b1;
            entry_id <= '0; entry_port <= '0; entry_address <= '0;
            load_out = 1'b1; state <= S_IDLE;
          end else if (idx < count) begin
            if (!used[slot] && (!have || xdist < best_d)) begin
              have <= 1'b1; best_d <= xdist; best <= slot;
            end
            idx <= idx + 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            ok <= 1'b1; entry_valid <= 1'b1;
            entry_id <= 64'(ids[best]); entry_port <= ports[best];
            entry_address <= addrs[best];
            last <= (emitted + 1'b1 == n_out);
            load_out = 1'b1;
            used[best] <= 1'b1;
            emitted <= emitted + 1'b1;
            idx <= '0; have <= 1'b0;
            state <= (emitted + 1'b1 == n_out) ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
      // A new result replaces the one taken; otherwise a taken result clears.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/kbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbt_checker: port-level checks for the k-bucket table
// Watches the ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module kbt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        ok,
  input wire logic        entry_valid,
  input wire logic        last,
  input wire logic [63:0] entry_id
);
  // A carried entry always reports ok.
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> ok) else $error("entry without ok");
  // An empty result carries a zero id.
  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> entry_id == 64'd0) else $error("stray id");
  // A result without an entry is always the final one.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !entry_valid |-> last) else $error("bare result not last");
  // No new command is taken in the cycle after an input transfer.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
  // A pending result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(last)) else $error("dropped");
endmodule

bind xor_distance_kbucket_table kbt_checker u_kbt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
  .entry_valid(entry_valid), .last(last), .entry_id(entry_id)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the k-bucket peer table
// Drives table commands under random idling and stalls, predicts each reply
// with a behavioural copy of the table, and compares replies field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import kbt_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        ev;
    logic [63:0] id;
    logic [15:0] port;
    logic [31:0] addr;
    logic        last;
  } reply_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] id;
    logic [15:0] port;
    logic [31:0] addr;
    logic [6:0]  want;
    logic        typed;
    logic        t_ok;
  } row_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] command = '0;
  logic [63:0] node_id = '0;
  logic [15:0] node_port = '0;
  logic [31:0] node_address = '0;
  logic [6:0] want_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok, entry_valid, last;
  logic [63:0] entry_id;
  logic [15:0] entry_port;
  logic [31:0] entry_address;

  xor_distance_kbucket_table dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_ready,
    .command, .node_id, .node_port, .node_address, .want_count,
    .out_valid, .out_ready, .ok, .entry_valid, .entry_id, .entry_port,
    .entry_address, .last
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the table, most recent entry in slot 0.
  logic [63:0] tab_id[$];
  logic [15:0] tab_port[$];
  logic [31:0] tab_addr[$];
  int unsigned cap_reg = 20;
  reply_t pending_replies[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_recv = 1'b0;
  int quiet_cycles = 0;
  logic [63:0] id_pool[8];

  function automatic int find_peer(logic [63:0] id);
    foreach (tab_id[i]) if (tab_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void queue_reply(logic okv, logic ev, int slot, logic lst);
    reply_t r;
    r.ok = okv;
    r.ev = ev;
    r.id = ev ? tab_id[slot] : '0;
    r.port = ev ? tab_port[slot] : '0;
    r.addr = ev ? tab_addr[slot] : '0;
    r.last = lst;
    pending_replies = {pending_replies, r};
  endfunction

  // Apply one command to the shadow table and queue its replies.
  function automatic void predict_table(row_t c);
    int s, n, best, lim;
    bit used[$];
    logic [63:0] d, bd;
    s = find_peer(c.id);
    lim = (cap_reg < CAPACITY) ? cap_reg : CAPACITY;
    case (c.cmd)
      CMD_ADD: begin
        if (s >= 0 || tab_id.size() < lim) begin
          if (s >= 0) begin
            tab_id.delete(s); tab_port.delete(s); tab_addr.delete(s);
          end
          tab_id.insert(0, c.id); tab_port.insert(0, c.port);
          tab_addr.insert(0, c.addr);
          queue_reply(1'b1, 1'b0, 0, 1'b1);
        end else begin
          queue_reply(1'b0, 1'b0, 0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (s >= 0) begin
          tab_id.delete(s); tab_port.delete(s); tab_addr.delete(s);
        end
        queue_reply(s >= 0, 1'b0, 0, 1'b1);
      end
      CMD_CONTAINS: queue_reply(s >= 0, 1'b0, 0, 1'b1);
      CMD_LIST: begin
        n = (c.want == 0 || c.want >= tab_id.size()) ? tab_id.size() : c.want;
        if (n == 0) queue_reply(1'b0, 1'b0, 0, 1'b1);
        for (int i = 0; i < n; i++) queue_reply(1'b1, 1'b1, i, i + 1 == n);
      end
      CMD_CLOSEST: begin
        n = (c.want < tab_id.size()) ? c.want : tab_id.size();
        if (n == 0) queue_reply(1'b0, 1'b0, 0, 1'b1);
        foreach (tab_id[j]) used = {used, 1'b0};
        for (int k = 0; k < n; k++) begin
          best = -1;
          bd = '0;
          foreach (tab_id[j]) begin
            d = tab_id[j] ^ c.id;
            if (!used[j] && (best < 0 || d < bd)) begin
              best = j;
              bd = d;
            end
          end
          used[best] = 1'b1;
          queue_reply(1'b1, 1'b1, best, k + 1 == n);
        end
      end
      default: queue_reply(1'b0, 1'b0, 0, 1'b1);
    endcase
  endfunction

  // Check every reply transfer against the oldest expectation.
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{ok, entry_valid, entry_id, entry_port, entry_address, last};
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected reply %p", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog on cycles with no transfer of any kind.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(row_t c);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    command <= c.cmd; node_id <= c.id; node_port <= c.port;
    node_address <= c.addr; want_count <= c.want; in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table(c);
    if (c.typed && pending_replies[$].ok !== c.t_ok) begin
      errors++;
      if (errors <= 10) $display("Table row expects ok %0d", c.t_ok);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_capacity(int unsigned v);
    drain_replies();
    cfg_data <= v[6:0]; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  function automatic row_t mk(logic [2:0] c, logic [63:0] id, logic [15:0] p,
                              logic [31:0] a, logic [6:0] w);
    row_t r;
    r = '{c, id, p, a, w, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic row_t rand_cmd();
    row_t r;
    r.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    if (r.cmd == CMD_ADD && $urandom_range(1)) r.cmd = CMD_ADD;
    r.id = $urandom_range(3) ? id_pool[$urandom_range(7)] ^ 64'($urandom_range(3))
                             : {$urandom, $urandom};
    r.port = 16'($urandom); r.addr = $urandom;
    r.want = $urandom_range(3) ? 7'($urandom_range(6)) : 7'($urandom_range(127));
    r.typed = 1'b0; r.t_ok = 1'b0;
    return r;
  endfunction

  // Directed table: typed ok only where obvious.
  row_t dir_rows[$];

  initial begin
    row_t r;
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    dir_rows = '{
      '{CMD_LIST, '0, '0, '0, 7'd0, 1'b1, 1'b0},
      '{CMD_CLOSEST, '0, '0, '0, 7'd5, 1'b1, 1'b0},
      '{CMD_CONTAINS, '1, '0, '0, 7'd0, 1'b1, 1'b0},
      '{CMD_REMOVE, '1, '0, '0, 7'd0, 1'b1, 1'b0},
      '{CMD_ADD, '0, '0, '0, 7'd0, 1'b1, 1'b1},
      '{CMD_ADD, '1, '1, '1, 7'h7f, 1'b1, 1'b1},
      '{CMD_ADD, 64'h5555_aaaa_0f0f_f0f0, 16'h1234, 32'h89ab_cdef, 7'd0, 1'b1, 1'b1},
      '{CMD_CONTAINS, '1, '0, '0, 7'd0, 1'b1, 1'b1},
      '{CMD_ADD, '0, 16'hbeef, 32'hdead_0001, 7'd0, 1'b1, 1'b1},
      '{CMD_LIST, '0, '0, '0, 7'd0, 1'b0, 1'b0},
      '{CMD_LIST, '0, '0, '0, 7'd2, 1'b0, 1'b0},
      '{CMD_LIST, '0, '0, '0, 7'h7f, 1'b0, 1'b0},
      '{CMD_CLOSEST, '1, '0, '0, 7'd64, 1'b0, 1'b0},
      '{CMD_CLOSEST, 64'h5555_aaaa_0f0f_f0f1, '0, '0, 7'd1, 1'b0, 1'b0},
      '{CMD_CLOSEST, '0, '0, '0, 7'd0, 1'b1, 1'b0},
      '{3'd5, '0, '0, '0, 7'd0, 1'b1, 1'b0},
      '{3'd7, '1, '1, '1, 7'h7f, 1'b1, 1'b0},
      '{CMD_REMOVE, '0, '0, '0, 7'd0, 1'b1, 1'b1},
      '{CMD_REMOVE, '0, '0, '0, 7'd0, 1'b1, 1'b0},
      '{CMD_LIST, '0, '0, '0, 7'd1, 1'b0, 1'b0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);

    // Capacity of one: two new ids are sent and both are refused.
    write_capacity(1);
    send_cmd(mk(CMD_ADD, 64'h1, 16'h1, 32'h1, 7'd0));
    send_cmd(mk(CMD_ADD, id_pool[0], 16'h2, 32'h2, 7'd0));
    // Capacity zero and the top of the field.
    write_capacity(0);
    send_cmd(mk(CMD_ADD, id_pool[1], 16'h3, 32'h3, 7'd0));
    write_capacity(127);

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 52; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 52; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      if (ph == 2) write_capacity(64);
      if (ph == 3) write_capacity(4);
      // Receiver holds off for a long stretch while commands keep coming.
      if (ph == 1) fork
        begin
          hold_recv = 1'b1;
          repeat (400) @(posedge clk);
          hold_recv = 1'b0;
        end
      join_none
      for (int i = 0; i < 22; i++) begin
        r = rand_cmd();
        send_cmd(r);
      end
      // Sender waits until all replies are in.
      drain_replies();
    end

    drain_replies();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
